[hdl/wps_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and helpers of the WS2812 pixel serializer.
package wps_pkg;

	localparam int PIXELS     = 16;
	localparam int PIX_AW     = $clog2(PIXELS);
	localparam int ACT_W      = $clog2(PIXELS + 1);
	localparam int COLOR_W    = 24;
	localparam int BIT_W      = $clog2(COLOR_W);
	localparam int TICK_W     = 16;
	localparam int CFG_DW     = 16;
	localparam int CFG_AW     = 3;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [1:0] OP_SET  = 2'd0;
	localparam logic [1:0] OP_GET  = 2'd1;
	localparam logic [1:0] OP_SHOW = 2'd2;
	localparam logic [1:0] OP_TICK = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_BUSY  = 2'd2;

	localparam logic [CFG_AW-1:0] REG_PIXEL_COUNT = 3'd0;
	localparam logic [CFG_AW-1:0] REG_ONE_HIGH    = 3'd1;
	localparam logic [CFG_AW-1:0] REG_ZERO_HIGH   = 3'd2;
	localparam logic [CFG_AW-1:0] REG_BIT_TICKS   = 3'd3;
	localparam logic [CFG_AW-1:0] REG_LATCH_TICKS = 3'd4;

	typedef struct packed {
		logic [4:0]        pixel_count;
		logic [7:0]        one_high_ticks;
		logic [7:0]        zero_high_ticks;
		logic [7:0]        bit_ticks;
		logic [TICK_W-1:0] latch_ticks;
	} cfg_t;

	// One classified command as it sits in the queue; color already in GRB order.
	typedef struct packed {
		logic [1:0]         op;
		logic [PIX_AW-1:0]  idx;
		logic               idx_ok;
		logic [COLOR_W-1:0] grb;
	} item_t;

	function automatic logic [ACT_W-1:0] active_count(input logic [4:0] cnt);
		logic [ACT_W-1:0] res;
		if (cnt > 5'(PIXELS))
			res = ACT_W'(PIXELS);
		else
			res = ACT_W'(cnt);
		return res;
	endfunction

	function automatic logic [COLOR_W-1:0] rgb_to_grb(input logic [COLOR_W-1:0] c);
		return {c[15:8], c[23:16], c[7:0]};
	endfunction

	function automatic logic [COLOR_W-1:0] grb_to_rgb(input logic [COLOR_W-1:0] w);
		return {w[15:8], w[23:16], w[7:0]};
	endfunction

endpackage

[hdl/ws2812_pixel_serializer.sv]
`timescale 1ns / 1ps
// Top level of the WS2812 pixel serializer: config registers, front end, queue, engine.
// A command taken at a clock edge is written into the queue, handled by the line engine at
// the queue head, and its result is registered and strobed by done; one command per cycle
// is sustained. busy never rises: the engine pops the queue in every cycle it holds a command.
// Reset (arst_n low, asynchronous) clears the pixel store to black, idles the line
// and loads the default timing; results cannot be stalled by the receiver.
module ws2812_pixel_serializer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  opcode,
	input  logic [7:0]                  pixel_index,
	input  logic [23:0]                 color,
	output logic                        done,
	output logic                        line_level,
	output logic [23:0]                 read_color,
	output logic                        busy_res,
	output logic [1:0]                  status,
	input  logic                        wr_en,
	input  logic [wps_pkg::CFG_AW-1:0]  wr_index,
	input  logic [wps_pkg::CFG_DW-1:0]  wr_data
);
	import wps_pkg::*;

	cfg_t             cfg_q;
	logic [ACT_W-1:0] active;
	logic             push, q_full, head_vld;
	item_t            push_item, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_count     <= 5'd12;
			cfg_q.one_high_ticks  <= 8'd16;
			cfg_q.zero_high_ticks <= 8'd8;
			cfg_q.bit_ticks       <= 8'd25;
			cfg_q.latch_ticks     <= 16'd1000;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PIXEL_COUNT: cfg_q.pixel_count     <= wr_data[4:0];
				REG_ONE_HIGH:    cfg_q.one_high_ticks  <= wr_data[7:0];
				REG_ZERO_HIGH:   cfg_q.zero_high_ticks <= wr_data[7:0];
				REG_BIT_TICKS:   cfg_q.bit_ticks       <= wr_data[7:0];
				REG_LATCH_TICKS: cfg_q.latch_ticks     <= wr_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign active = active_count(cfg_q.pixel_count);
	assign busy   = q_full;

	wps_front u_front (
		.start       (start),
		.q_full      (q_full),
		.opcode      (opcode),
		.pixel_index (pixel_index),
		.color       (color),
		.active      (active),
		.push        (push),
		.item        (push_item)
	);

	wps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.head_vld  (head_vld),
		.head      (head)
	);

	wps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_vld   (head_vld),
		.head       (head),
		.cfg        (cfg_q),
		.active     (active),
		.done       (done),
		.line_level (line_level),
		.read_color (read_color),
		.busy_res   (busy_res),
		.status     (status)
	);

endmodule

[hdl/wps_front.sv]
`timescale 1ns / 1ps
// Command front end: takes commands, range-checks the index, reorders the color.
module wps_front (
	input  logic                      start,
	input  logic                      q_full,
	input  logic [1:0]                opcode,
	input  logic [7:0]                pixel_index,
	input  logic [23:0]               color,
	input  logic [wps_pkg::ACT_W-1:0] active,
	output logic                      push,
	output wps_pkg::item_t            item
);
	import wps_pkg::*;

	assign push = start && !q_full;

	always_comb begin
		item.op     = opcode;
		item.idx    = pixel_index[PIX_AW-1:0];
		item.idx_ok = 1'b0;
		item.grb    = '0;
		unique case (opcode)
			OP_SET: begin
				item.idx_ok = pixel_index < 8'(active);
				item.grb    = rgb_to_grb(color);
			end
			OP_GET: begin
				item.idx_ok = pixel_index < 8'(active);
			end
			default: begin
			end
		endcase
	end

endmodule

[hdl/wps_queue.sv]
`timescale 1ns / 1ps
// Short command queue between the front end and the line engine.
module wps_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wps_pkg::item_t push_item,
	output logic           full,
	output logic           head_vld,
	output wps_pkg::item_t head
);
	import wps_pkg::*;

	item_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;

	assign full     = cnt_q == QCNT_W'(QDEPTH);
	assign head_vld = cnt_q != '0;
	assign pop      = head_vld;	// engine drains one command per cycle
	assign head     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

endmodule

[hdl/wps_back.sv]
`timescale 1ns / 1ps
// Line engine: pixel store, frame/latch sequencer and result register.
module wps_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      head_vld,
	input  wps_pkg::item_t            head,
	input  wps_pkg::cfg_t             cfg,
	input  logic [wps_pkg::ACT_W-1:0] active,
	output logic                      done,
	output logic                      line_level,
	output logic [23:0]               read_color,
	output logic                      busy_res,
	output logic [1:0]                status
);
	import wps_pkg::*;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_SEND  = 2'd1;
	localparam logic [1:0] PH_LATCH = 2'd2;

	logic [COLOR_W-1:0] mem [PIXELS];
	logic [PIXELS-1:0]  vld_q;

	logic [1:0]        phase_q, phase_d;
	logic [PIX_AW-1:0] pix_q, pix_d;
	logic [BIT_W-1:0]  bit_q, bit_d;
	logic [TICK_W-1:0] tick_q, tick_d;
	logic              line_q, line_d;

	logic [COLOR_W-1:0] word_q;
	logic               word_vld_q;
	logic [COLOR_W-1:0] rd_word_q;
	logic               rd_vld_q;

	logic       done_q, lvl_q, busy_q, rdok_q;
	logic [1:0] st_q;

	logic              busy, we, rd_ok, lvl, bit_val, send_lvl;
	logic [1:0]        st;
	logic [BIT_W-1:0]  bsel;
	logic [7:0]        high, period;
	logic [TICK_W-1:0] latch_len;
	logic [TICK_W:0]   tick_inc;
	logic [ACT_W-1:0]  pix_next;

	assign busy      = phase_q != PH_IDLE;
	assign bsel      = BIT_W'(COLOR_W - 1) - bit_q;
	assign bit_val   = word_vld_q && word_q[bsel];
	assign high      = bit_val ? cfg.one_high_ticks : cfg.zero_high_ticks;
	assign send_lvl  = tick_q < TICK_W'(high);
	assign period    = (cfg.bit_ticks == '0) ? 8'd1 : cfg.bit_ticks;
	assign latch_len = (cfg.latch_ticks == '0) ? TICK_W'(1) : cfg.latch_ticks;
	assign tick_inc  = {1'b0, tick_q} + 1'b1;

	always_comb begin
		phase_d  = phase_q;
		pix_d    = pix_q;
		bit_d    = bit_q;
		tick_d   = tick_q;
		line_d   = line_q;
		lvl      = line_q;
		rd_ok    = 1'b0;
		we       = 1'b0;
		st       = ST_OK;
		pix_next = ACT_W'(pix_q);
		if (head_vld) begin
			unique case (head.op)
				OP_SET: begin
					if (busy)
						st = ST_BUSY;
					else if (!head.idx_ok)
						st = ST_RANGE;
					else
						we = 1'b1;
				end
				OP_GET: begin
					if (!head.idx_ok)
						st = ST_RANGE;
					else
						rd_ok = 1'b1;
				end
				OP_SHOW: begin
					if (busy) begin
						st = ST_BUSY;
					end else begin
						pix_d   = '0;
						bit_d   = '0;
						tick_d  = '0;
						line_d  = 1'b0;
						lvl     = 1'b0;
						phase_d = (active != '0) ? PH_SEND : PH_LATCH;
					end
				end
				default: begin
					lvl = 1'b0;
					unique case (phase_q)
						PH_SEND: begin
							lvl    = send_lvl;
							tick_d = tick_inc[TICK_W-1:0];
							if (tick_inc >= (TICK_W + 1)'(period)) begin
								tick_d = '0;
								if (bit_q == BIT_W'(COLOR_W - 1)) begin
									bit_d    = '0;
									pix_next = ACT_W'(pix_q) + 1'b1;
								end else begin
									bit_d = bit_q + 1'b1;
								end
								if (pix_next >= active) begin
									phase_d = PH_LATCH;
									pix_d   = '0;
									bit_d   = '0;
								end else begin
									pix_d = pix_next[PIX_AW-1:0];
								end
							end
						end
						PH_LATCH: begin
							tick_d = tick_inc[TICK_W-1:0];
							if (tick_inc >= (TICK_W + 1)'(latch_len)) begin
								tick_d  = '0;
								phase_d = PH_IDLE;
							end
						end
						default: begin
						end
					endcase
					line_d = lvl;
				end
			endcase
		end
	end

	// Store writes happen only while idle, so the frame word read never races a write.
	always_ff @(posedge clk) begin
		if (we)
			mem[head.idx] <= head.grb;
		rd_word_q <= mem[head.idx];
		word_q    <= mem[pix_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_vld_q   <= 1'b0;
			word_vld_q <= 1'b0;
		end else begin
			if (we)
				vld_q[head.idx] <= 1'b1;
			rd_vld_q   <= vld_q[head.idx];
			word_vld_q <= vld_q[pix_d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pix_q   <= '0;
			bit_q   <= '0;
			tick_q  <= '0;
			line_q  <= 1'b0;
			done_q  <= 1'b0;
			lvl_q   <= 1'b0;
			busy_q  <= 1'b0;
			rdok_q  <= 1'b0;
			st_q    <= ST_OK;
		end else begin
			phase_q <= phase_d;
			pix_q   <= pix_d;
			bit_q   <= bit_d;
			tick_q  <= tick_d;
			line_q  <= line_d;
			done_q  <= head_vld;
			if (head_vld) begin
				lvl_q  <= lvl;
				busy_q <= phase_d != PH_IDLE;
				rdok_q <= rd_ok;
				st_q   <= st;
			end
		end
	end

	assign done       = done_q;
	assign line_level = lvl_q;
	assign busy_res   = busy_q;
	assign status     = st_q;
	assign read_color = (rdok_q && rd_vld_q) ? grb_to_rgb(rd_word_q) : '0;

endmodule
